@@ hdl/spi_mse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_mse_pkg
// Shared types, constants and helpers for the tick-driven SPI master engine.
// ----------------------------------------------------------------------------
package spi_mse_pkg;

    localparam int WORD_WIDTH = 16;
    localparam int IDX_W      = $clog2(WORD_WIDTH);
    localparam int TICK_W     = 10;
    localparam int BITS_W     = 5;
    localparam int HIGH_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [BITS_W-1:0] BIT_COUNT_RST   = BITS_W'(16);
    localparam logic [TICK_W-1:0] HALF_PERIOD_RST = TICK_W'(25);
    localparam logic [TICK_W-1:0] GUARD_RST       = TICK_W'(100);
    localparam logic [TICK_W-1:0] READ_GAP_RST    = TICK_W'(10);
    localparam logic [HIGH_W-1:0] READ_HIGH_RST   = HIGH_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_COUNT   = 3'd0,
        REG_HALF_PERIOD = 3'd1,
        REG_GUARD       = 3'd2,
        REG_READ_GAP    = 3'd3,
        REG_READ_HIGH   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RESTORE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WGUARD = 3'd1,
        PH_WSETUP = 3'd2,
        PH_WHIGH  = 3'd3,
        PH_WTAIL  = 3'd4,
        PH_RGAP   = 3'd5,
        PH_RHIGH  = 3'd6,
        PH_RLOW   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [BITS_W-1:0] bit_count;
        logic [TICK_W-1:0] half_period;
        logic [TICK_W-1:0] guard;
        logic [TICK_W-1:0] read_gap;
        logic [HIGH_W-1:0] read_high;
    } cfg_t;

    typedef struct packed {
        logic                  select_n;
        logic                  clock_out;
        logic                  data_out;
        logic                  busy;
        logic                  done;
        logic [WORD_WIDTH-1:0] read_data;
    } res_t;

    // Index of the first (most significant) bit; zero count acts as one,
    // counts beyond the word act as the full word.
    function automatic logic [IDX_W-1:0] first_index(input logic [BITS_W-1:0] bc);
        logic [IDX_W-1:0] idx;
        if (bc == '0) begin
            idx = '0;
        end else if (int'(bc) > WORD_WIDTH) begin
            idx = IDX_W'(WORD_WIDTH - 1);
        end else begin
            idx = IDX_W'(bc - BITS_W'(1));
        end
        return idx;
    endfunction

endpackage

@@ hdl/spi_mse_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_mse_cfg_regs
// Timing and length registers, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module spi_mse_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [spi_mse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spi_mse_pkg::CFG_DATA_W-1:0] cfg_data,
    output spi_mse_pkg::cfg_t                cfg
);
    import spi_mse_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_count   <= BIT_COUNT_RST;
            cfg_reg.half_period <= HALF_PERIOD_RST;
            cfg_reg.guard       <= GUARD_RST;
            cfg_reg.read_gap    <= READ_GAP_RST;
            cfg_reg.read_high   <= READ_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BIT_COUNT:   cfg_reg.bit_count   <= cfg_data[BITS_W-1:0];
                REG_HALF_PERIOD: cfg_reg.half_period <= cfg_data[TICK_W-1:0];
                REG_GUARD:       cfg_reg.guard       <= cfg_data[TICK_W-1:0];
                REG_READ_GAP:    cfg_reg.read_gap    <= cfg_data[TICK_W-1:0];
                REG_READ_HIGH:   cfg_reg.read_high   <= cfg_data[HIGH_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/spi_mse_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_mse_core
// Transfer sequencer: advances one tick per accepted word, shows next pins.
// ----------------------------------------------------------------------------
module spi_mse_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  spi_mse_pkg::cfg_t                   cfg,
    input  logic [1:0]                          command,
    input  logic [spi_mse_pkg::WORD_WIDTH-1:0]  tx_data,
    input  logic                                sdi,
    output spi_mse_pkg::res_t                   res
);
    import spi_mse_pkg::*;

    phase_t                phase_reg,   phase_next;
    logic [TICK_W-1:0]     tick_reg,    tick_next;
    logic [IDX_W-1:0]      idx_reg,     idx_next;
    logic [WORD_WIDTH-1:0] send_reg,    send_next;
    logic [WORD_WIDTH-1:0] recv_reg,    recv_next;
    logic                  sel_reg,     sel_next;
    logic                  clk_lvl_reg, clk_lvl_next;
    logic                  dat_reg,     dat_next;
    logic                  done;

    logic [TICK_W-1:0]     tick_inc;
    logic [TICK_W-1:0]     limit;
    logic                  wait_done;
    cmd_t                  cmd;

    assign cmd      = cmd_t'(command);
    assign tick_inc = tick_reg + TICK_W'(1);

    always_comb
    begin
        case (phase_reg)
            PH_WGUARD, PH_WTAIL: limit = cfg.guard;
            PH_WSETUP, PH_WHIGH: limit = cfg.half_period;
            PH_RGAP:             limit = cfg.read_gap;
            PH_RHIGH:            limit = TICK_W'(cfg.read_high);
            default:             limit = '0;
        endcase
    end

    assign wait_done = (tick_inc >= limit);

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        idx_next     = idx_reg;
        send_next    = send_reg;
        recv_next    = recv_reg;
        sel_next     = sel_reg;
        clk_lvl_next = clk_lvl_reg;
        dat_next     = dat_reg;
        done         = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                case (cmd)
                    CMD_WRITE:
                    begin
                        send_next  = tx_data;
                        idx_next   = first_index(cfg.bit_count);
                        sel_next   = 1'b0;
                        tick_next  = '0;
                        phase_next = PH_WGUARD;
                    end
                    CMD_READ:
                    begin
                        recv_next  = '0;
                        idx_next   = first_index(cfg.bit_count);
                        sel_next   = 1'b1;
                        tick_next  = '0;
                        phase_next = PH_RGAP;
                    end
                    CMD_RESTORE:
                    begin
                        sel_next     = 1'b1;
                        clk_lvl_next = 1'b1;
                        dat_next     = 1'b0;
                    end
                    default: ;
                endcase
            end
            PH_WGUARD:
            begin
                tick_next = wait_done ? '0 : tick_inc;
                if (wait_done)
                begin
                    dat_next   = send_reg[idx_reg];
                    phase_next = PH_WSETUP;
                end
            end
            PH_WSETUP:
            begin
                tick_next = wait_done ? '0 : tick_inc;
                if (wait_done)
                begin
                    clk_lvl_next = 1'b1;
                    phase_next   = PH_WHIGH;
                end
            end
            PH_WHIGH:
            begin
                tick_next = wait_done ? '0 : tick_inc;
                if (wait_done)
                begin
                    clk_lvl_next = 1'b0;
                    if (idx_reg == '0)
                    begin
                        phase_next = PH_WTAIL;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        dat_next   = send_reg[idx_reg - IDX_W'(1)];
                        phase_next = PH_WSETUP;
                    end
                end
            end
            PH_WTAIL:
            begin
                tick_next = wait_done ? '0 : tick_inc;
                if (wait_done)
                begin
                    sel_next   = 1'b1;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            end
            PH_RGAP:
            begin
                tick_next = wait_done ? '0 : tick_inc;
                if (wait_done)
                begin
                    sel_next     = 1'b0;
                    clk_lvl_next = 1'b1;
                    phase_next   = PH_RHIGH;
                end
            end
            PH_RHIGH:
            begin
                tick_next = wait_done ? '0 : tick_inc;
                if (wait_done)
                begin
                    if (sdi)
                    begin
                        recv_next[idx_reg] = 1'b1;
                    end
                    clk_lvl_next = 1'b0;
                    phase_next   = PH_RLOW;
                end
            end
            PH_RLOW:
            begin
                tick_next = '0;
                if (idx_reg == '0)
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                else
                begin
                    idx_next     = idx_reg - IDX_W'(1);
                    clk_lvl_next = 1'b1;
                    phase_next   = PH_RHIGH;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            idx_reg     <= '0;
            send_reg    <= '0;
            recv_reg    <= '0;
            sel_reg     <= 1'b1;
            clk_lvl_reg <= 1'b1;
            dat_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            idx_reg     <= idx_next;
            send_reg    <= send_next;
            recv_reg    <= recv_next;
            sel_reg     <= sel_next;
            clk_lvl_reg <= clk_lvl_next;
            dat_reg     <= dat_next;
        end
    end

    assign res.select_n  = sel_next;
    assign res.clock_out = clk_lvl_next;
    assign res.data_out  = dat_next;
    assign res.busy      = (phase_next != PH_IDLE);
    assign res.done      = done;
    assign res.read_data = recv_next;

    // Select stays low through the write bit phases.
    a_write_select_low: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WSETUP || phase_reg == PH_WHIGH) |-> !sel_reg)
        else $error("select high during write bits");

    // The low tick of a read always follows a sample with the clock low.
    a_read_low_clock: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RLOW) |-> !clk_lvl_reg)
        else $error("clock high in read low tick");

    // Entering a read bit raises the clock.
    a_rhigh_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg != PH_RHIGH && phase_next == PH_RHIGH)
        |=> (clk_lvl_reg && phase_reg == PH_RHIGH))
        else $error("read bit entered without clock high");

endmodule

@@ hdl/spi_master_shift_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_shift_engine_unit
// Tick-driven SPI master with a registered result channel.
// ----------------------------------------------------------------------------
// Usage:
//   Every input word is one tick of the pin waveform: a command (tick only,
//   start write, start read, restore idle levels), the word to send and the
//   sampled sdi level. Each accepted word yields exactly one result word with
//   the pin levels after that tick (select_n, clock_out, data_out), busy_res,
//   a done_res pulse on the finishing tick, and the receive word.
//   Input is taken when in_valid is high and in_stall is low; results leave
//   when out_valid is high and out_stall is low.
//   The result appears in the cycle after its word is accepted.
//   Throughput: one word per cycle. The sequencer state and the result
//   register both load in the accepting cycle, so back-to-back ticks flow unless a result is held by out_stall.
//   When the receiver stalls, hold the result; in_stall goes high only while
//   a result waits and out_stall is high, and the sequencer does not advance.
//   Reset: idle, select high, clock high, data low, receive word zero; the
//   registers return to 16 bits, half period 25, guard 100, gap 10, high 1.
//   Configuration: write only while no transfer is running and no result
//   is pending; cfg_ready is always high.
// ----------------------------------------------------------------------------
module spi_master_shift_engine_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            command,
    input  logic [spi_mse_pkg::WORD_WIDTH-1:0]    tx_data,
    input  logic                                  sdi,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  select_n,
    output logic                                  clock_out,
    output logic                                  data_out,
    output logic                                  busy_res,
    output logic                                  done_res,
    output logic [spi_mse_pkg::WORD_WIDTH-1:0]    read_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [spi_mse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spi_mse_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import spi_mse_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;
    logic step;

    // Stall the sender only while a result is parked and not taken.
    assign in_stall = out_valid_reg && out_stall;
    assign step     = in_valid && !in_stall;

    spi_mse_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spi_mse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .cfg     (cfg),
        .command (command),
        .tx_data (tx_data),
        .sdi     (sdi),
        .res     (res)
    );

    // Result register: load on accept, drop valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign select_n  = res_reg.select_n;
    assign clock_out = res_reg.clock_out;
    assign data_out  = res_reg.data_out;
    assign busy_res  = res_reg.busy;
    assign done_res  = res_reg.done;
    assign read_data = res_reg.read_data;

    // A finished transfer never reports busy on the same tick.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done) |-> !res_reg.busy)
        else $error("done with busy set");

    // A new result only appears after an accepted word.
    a_valid_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step))
        else $error("result without accepted word");

endmodule
